>>> design/crtc_pkg.sv
// Shared types and constants for the call/return trace capture block.
// No dependencies; every other file imports this package.
package crtc_pkg;

  localparam int TARGETS   = 4;     // targets that the sequencer may walk
  localparam int TGT_SLOTS = 4;     // per-target state slots, one per 2-bit index
  localparam int RECORDS   = 64;    // depth of the record store

  localparam int IDX_W  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int FILL_W = $clog2(RECORDS + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;
  localparam int CFG_IDX_W = 3;

  // Input opcodes
  localparam logic [1:0] OP_OBSERVE   = 2'd0;
  localparam logic [1:0] OP_SET_FIELD = 2'd1;
  localparam logic [1:0] OP_DRAIN     = 2'd2;

  // Record kinds
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_RETURN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAPACITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PC_0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PC_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PC_2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PC_3    = 3'd6;

  // Return addresses must be word aligned
  localparam logic [31:0] ALIGN_MASK = 32'h0000_0003;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        inst_pc;
    logic [31:0]        following_pc;
    logic [31:0]        inst_word;
    logic               in_delay_slot;
    logic [5:0]         pending_load_reg;
    logic [31:0]        pending_load_value;
    logic signed [31:0] cycle_stamp;
    logic [31:0]        stack_pointer;
    logic [31:0]        return_address;
    logic [31:0]        field_number;
  } crtc_item_t;

  typedef struct packed {
    logic               record_present;
    logic [31:0]        rec_ordinal;
    logic [31:0]        rec_field;
    logic [1:0]         rec_target;
    logic               rec_kind;
    logic [31:0]        rec_pc;
    logic [31:0]        rec_next_pc;
    logic [31:0]        rec_inst;
    logic               rec_delay_slot;
    logic [5:0]         rec_load_reg;
    logic [31:0]        rec_load_value;
    logic signed [31:0] rec_stamp;
  } crtc_result_t;

  // One stored record
  typedef struct packed {
    logic [31:0]        ordinal;
    logic [31:0]        field;
    logic [1:0]         target;
    logic               kind;
    logic [31:0]        pc;
    logic [31:0]        next_pc;
    logic [31:0]        inst;
    logic               delay_slot;
    logic [5:0]         load_reg;
    logic [31:0]        load_data;
    logic signed [31:0] stamp;
  } crtc_rec_t;

  typedef struct packed {
    logic [2:0]             n_targets;
    logic [6:0]             queue_capacity;
    logic [3:0]             follow_mask;
    logic [3:0][31:0]       target_pc;
  } crtc_cfg_t;

  // Sequencer requests to the record store
  typedef struct packed {
    logic push;
    logic pop;
  } crtc_fifo_req_t;

endpackage

>>> design/crtc_in_if.sv
// Input item channel: valid/ready handshake with an observe/set/drain item.
// Depends on crtc_pkg for the payload type.
interface crtc_in_if import crtc_pkg::*; ();
  logic       valid;
  logic       ready;
  crtc_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/crtc_out_if.sv
// Result item channel: valid/ready handshake carrying one drained record.
// Depends on crtc_pkg for the payload type.
interface crtc_out_if import crtc_pkg::*; ();
  logic         valid;
  logic         ready;
  crtc_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/call_return_trace_capture.sv
// Call/return trace capture top level: configuration registers, output
// register, sequencer and record store. Depends on crtc_pkg, crtc_in_if,
// crtc_out_if, crtc_seq and crtc_fifo.
//
// Usage: items arrive on in_ch. An observe item checks each active target in
// turn for a return and then an entry, appending a record per match to the
// store (or counting a drop when full). A set_field item latches the field
// number. A drain item pops the oldest record and returns exactly one result
// on out_ch: record_present 0 with all fields zero when the store is empty.
// Timing: an observe item occupies the block for a return step and an entry
// step per active target (two comparator steps per target through the one
// shared address compare); a drain's result passes through the registered
// RAM read and then the output register. in_ch.ready is high only while idle.
// A stalled receiver holds the result in the output register; a further
// drain waits in the sequencer, with the input held off, until that register
// empties. Synchronous reset empties the store, clears all counters and
// pending returns, and restores the register defaults (one target, capacity
// 64, no follow bits, target addresses zero). cfg_we writes at once.
module call_return_trace_capture import crtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  crtc_in_if.sink              in_ch,
  crtc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  crtc_cfg_t      cfg_r;
  crtc_fifo_req_t fifo_req;
  crtc_rec_t      wr_rec;
  crtc_rec_t      rd_rec;
  logic           rd_present;
  logic           out_load;
  logic           out_free;
  logic           out_valid_r;
  crtc_result_t   out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.n_targets      <= 3'd1;
      cfg_r.queue_capacity <= 7'd64;
      cfg_r.follow_mask    <= '0;
      cfg_r.target_pc      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_COUNT:   cfg_r.n_targets      <= cfg_wdata[2:0];
        REG_QUEUE_CAPACITY: cfg_r.queue_capacity <= cfg_wdata[6:0];
        REG_FOLLOW_MASK:    cfg_r.follow_mask    <= cfg_wdata[3:0];
        REG_TARGET_PC_0:    cfg_r.target_pc[0]   <= cfg_wdata;
        REG_TARGET_PC_1:    cfg_r.target_pc[1]   <= cfg_wdata;
        REG_TARGET_PC_2:    cfg_r.target_pc[2]   <= cfg_wdata;
        REG_TARGET_PC_3:    cfg_r.target_pc[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crtc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .in_ready (in_ch.ready),
    .fifo_req (fifo_req),
    .wr_rec   (wr_rec),
    .out_free (out_free),
    .out_load (out_load)
  );

  crtc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (cfg_r.queue_capacity),
    .req        (fifo_req),
    .wr_rec     (wr_rec),
    .rd_rec     (rd_rec),
    .rd_present (rd_present)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the popped record, or zero every field of an empty drain
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rd_present) begin
        out_r.record_present <= 1'b1;
        out_r.rec_ordinal    <= rd_rec.ordinal;
        out_r.rec_field      <= rd_rec.field;
        out_r.rec_target     <= rd_rec.target;
        out_r.rec_kind       <= rd_rec.kind;
        out_r.rec_pc         <= rd_rec.pc;
        out_r.rec_next_pc    <= rd_rec.next_pc;
        out_r.rec_inst       <= rd_rec.inst;
        out_r.rec_delay_slot <= rd_rec.delay_slot;
        out_r.rec_load_reg   <= rd_rec.load_reg;
        out_r.rec_load_value <= rd_rec.load_data;
        out_r.rec_stamp      <= rd_rec.stamp;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

>>> design/crtc_fifo.sv
// Record store: circular buffer in a RAM with head, fill and capacity check.
// Depends on crtc_pkg.
module crtc_fifo import crtc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [6:0]     capacity,
  input  crtc_fifo_req_t req,
  input  crtc_rec_t      wr_rec,
  output crtc_rec_t      rd_rec,
  output logic           rd_present
);

  crtc_rec_t mem_r [RECORDS];
  crtc_rec_t rd_rec_r;
  logic      rd_present_r;

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       drop_count_r, drop_count_nxt;

  logic [CMP_W-1:0]  cap_ext;
  logic              has_room;
  logic              do_push;
  logic [SUM_W-1:0]  slot_sum;
  logic [IDX_W-1:0]  wr_slot;

  assign cap_ext  = CMP_W'(capacity);
  assign has_room = (CMP_W'(fill_r) < cap_ext) && (fill_r < FILL_W'(RECORDS));
  assign do_push  = req.push && has_room;

  // Head plus fill stays below twice the depth: one subtract wraps it
  assign slot_sum = SUM_W'(head_r) + SUM_W'(fill_r);
  assign wr_slot  = (slot_sum >= SUM_W'(RECORDS)) ? IDX_W'(slot_sum - SUM_W'(RECORDS))
                                                  : IDX_W'(slot_sum);

  always_comb begin
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    drop_count_nxt = drop_count_r;
    if (req.push) begin
      if (has_room) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else begin
        drop_count_nxt = drop_count_r + 32'd1;
      end
    end else if (req.pop && (fill_r != '0)) begin
      fill_nxt = fill_r - FILL_W'(1);
      head_nxt = (head_r == IDX_W'(RECORDS - 1)) ? '0 : head_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fill_r       <= '0;
      drop_count_r <= '0;
      rd_present_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      drop_count_r <= drop_count_nxt;
      if (req.pop) begin
        rd_present_r <= (fill_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_slot] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (req.pop) begin
      rd_rec_r <= mem_r[head_r];
    end
  end

  assign rd_rec     = rd_rec_r;
  assign rd_present = rd_present_r;

endmodule

>>> design/crtc_seq.sv
// Sequencer: walks the targets one check at a time through a shared address
// comparator, keeps the per-target pairing state and counters. Uses crtc_pkg.
module crtc_seq import crtc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  crtc_cfg_t      cfg,
  input  logic           in_valid,
  input  crtc_item_t     in_item,
  output logic           in_ready,
  output crtc_fifo_req_t fifo_req,
  output crtc_rec_t      wr_rec,
  input  logic           out_free,
  output logic           out_load
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RET   = 5'b00010,
    S_ENT   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  crtc_item_t  item_r;
  logic [1:0]  tgt_r, tgt_nxt;
  logic [1:0]  last_tgt_r, last_tgt_nxt;
  logic [31:0] observed_count_r, observed_count_nxt;
  logic [31:0] latched_field_r, latched_field_nxt;
  logic [31:0] pair_err_count_r, pair_err_count_nxt;

  logic [TGT_SLOTS-1:0] pending_r;
  logic [31:0]          saved_pc_r   [TGT_SLOTS];
  logic [31:0]          saved_sp_r   [TGT_SLOTS];
  logic [31:0]          entry_cnt_r  [TGT_SLOTS];
  logic [31:0]          return_cnt_r [TGT_SLOTS];

  logic [2:0]  active_count;
  logic [31:0] cmp_ref;
  logic        cmp_hit;
  logic        ret_hit;
  logic        ent_hit;
  logic        follow;
  logic        pair_bad;
  logic        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Saturate the target count at the number of targets built
  assign active_count = (cfg.n_targets > 3'(TARGETS)) ? 3'(TARGETS) : cfg.n_targets;

  // Shared comparator: saved return address in the return step, target pc otherwise
  assign cmp_ref = (state_r == S_RET) ? saved_pc_r[tgt_r] : cfg.target_pc[tgt_r];
  assign cmp_hit = (item_r.inst_pc == cmp_ref);

  assign ret_hit  = (state_r == S_RET) && pending_r[tgt_r] && cmp_hit &&
                    (item_r.stack_pointer == saved_sp_r[tgt_r]) && !item_r.in_delay_slot;
  assign ent_hit  = (state_r == S_ENT) && cmp_hit;
  assign follow   = cfg.follow_mask[tgt_r];
  assign pair_bad = pending_r[tgt_r] || ((item_r.return_address & ALIGN_MASK) != '0);

  always_comb begin
    wr_rec.ordinal    = observed_count_r;
    wr_rec.field      = latched_field_r;
    wr_rec.target     = tgt_r;
    wr_rec.kind       = (state_r == S_RET) ? KIND_RETURN : KIND_ENTRY;
    wr_rec.pc         = item_r.inst_pc;
    wr_rec.next_pc    = item_r.following_pc;
    wr_rec.inst       = item_r.inst_word;
    wr_rec.delay_slot = item_r.in_delay_slot;
    wr_rec.load_reg   = item_r.pending_load_reg;
    wr_rec.load_data  = item_r.pending_load_value;
    wr_rec.stamp      = item_r.cycle_stamp;
  end

  always_comb begin
    state_nxt          = state_r;
    tgt_nxt            = tgt_r;
    last_tgt_nxt       = last_tgt_r;
    observed_count_nxt = observed_count_r;
    latched_field_nxt  = latched_field_r;
    pair_err_count_nxt = pair_err_count_r;
    fifo_req.push      = ret_hit || ent_hit;
    fifo_req.pop       = 1'b0;
    out_load           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.opcode)
            OP_OBSERVE: begin
              observed_count_nxt = observed_count_r + 32'd1;
              tgt_nxt            = 2'd0;
              last_tgt_nxt       = 2'(active_count - 3'd1);
              if (active_count != 3'd0) begin
                state_nxt = S_RET;
              end
            end
            OP_SET_FIELD: latched_field_nxt = in_item.field_number;
            OP_DRAIN:     state_nxt = S_DRAIN;
            default:      ;
          endcase
        end
      end
      S_RET: state_nxt = S_ENT;
      S_ENT: begin
        if (ent_hit && follow && pair_bad) begin
          pair_err_count_nxt = pair_err_count_r + 32'd1;
        end
        if (tgt_r == last_tgt_r) begin
          state_nxt = S_IDLE;
        end else begin
          tgt_nxt   = tgt_r + 2'd1;
          state_nxt = S_RET;
        end
      end
      S_DRAIN: begin
        // Hold until the output register is free or being emptied
        if (out_free) begin
          fifo_req.pop = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      tgt_r            <= '0;
      last_tgt_r       <= '0;
      observed_count_r <= '0;
      latched_field_r  <= '0;
      pair_err_count_r <= '0;
      pending_r        <= '0;
      for (int i = 0; i < TGT_SLOTS; i++) begin
        entry_cnt_r[i]  <= '0;
        return_cnt_r[i] <= '0;
      end
    end else begin
      state_r          <= state_nxt;
      tgt_r            <= tgt_nxt;
      last_tgt_r       <= last_tgt_nxt;
      observed_count_r <= observed_count_nxt;
      latched_field_r  <= latched_field_nxt;
      pair_err_count_r <= pair_err_count_nxt;
      if (ret_hit) begin
        pending_r[tgt_r]    <= 1'b0;
        return_cnt_r[tgt_r] <= return_cnt_r[tgt_r] + 32'd1;
      end
      if (ent_hit) begin
        entry_cnt_r[tgt_r] <= entry_cnt_r[tgt_r] + 32'd1;
        if (follow && !pair_bad) begin
          pending_r[tgt_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (ent_hit && follow && !pair_bad) begin
      saved_pc_r[tgt_r] <= item_r.return_address;
      saved_sp_r[tgt_r] <= item_r.stack_pointer;
    end
  end

endmodule

>>> bench/tb_call_return_trace_capture.sv
`timescale 1ns / 100ps
// Self-checking bench for call_return_trace_capture: directed and random
// observe/set_field/drain items against a built-in record predictor.
// Depends on crtc_pkg, crtc_in_if, crtc_out_if and the block itself.
module tb_call_return_trace_capture import crtc_pkg::*; ();

  localparam logic [1:0] OP_UNUSED = 2'd3;  // no operation; block ignores it
  localparam int SETTLE_CYCLES  = 24;       // margin for the longest observe, which walks all four targets
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // Predicts drained records from accepted items and checks drained results.
  class capture_board;
    logic [2:0]   tgt_count;
    logic [6:0]   capacity;
    logic [3:0]   follow;
    logic [31:0]  tgt_pc [TARGETS];
    logic [31:0]  n_observed;
    logic [31:0]  field;
    bit           pending [TARGETS];
    logic [31:0]  ret_pc [TARGETS];
    logic [31:0]  ret_sp [TARGETS];
    crtc_rec_t    records [$];
    crtc_result_t expected_drains [$];
    int           errors;

    function new();
      tgt_count  = 3'd1;
      capacity   = 7'd64;
      follow     = '0;
      n_observed = '0;
      field      = '0;
      errors     = 0;
      foreach (tgt_pc[t]) begin
        tgt_pc[t]  = '0;
        pending[t] = 1'b0;
        ret_pc[t]  = '0;
        ret_sp[t]  = '0;
      end
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_TARGET_COUNT:   tgt_count = data[2:0];
        REG_QUEUE_CAPACITY: capacity  = data[6:0];
        REG_FOLLOW_MASK:    follow    = data[3:0];
        REG_TARGET_PC_0:    tgt_pc[0] = data;
        REG_TARGET_PC_1:    tgt_pc[1] = data;
        REG_TARGET_PC_2:    tgt_pc[2] = data;
        REG_TARGET_PC_3:    tgt_pc[3] = data;
        default: ;
      endcase
    endfunction

    // Append one record, or drop it when the store is at capacity
    function void store_match(int t, logic kind, crtc_item_t it);
      crtc_rec_t r;
      int cap;
      cap = (capacity > RECORDS) ? RECORDS : capacity;
      if (records.size() >= cap) return;
      r.ordinal    = n_observed;
      r.field      = field;
      r.target     = 2'(t);
      r.kind       = kind;
      r.pc         = it.inst_pc;
      r.next_pc    = it.following_pc;
      r.inst       = it.inst_word;
      r.delay_slot = it.in_delay_slot;
      r.load_reg   = it.pending_load_reg;
      r.load_data  = it.pending_load_value;
      r.stamp      = it.cycle_stamp;
      records.push_back(r);
    endfunction

    function void predict_item(crtc_item_t it);
      crtc_result_t res;
      crtc_rec_t r;
      int active;
      int t;
      case (it.opcode)
        OP_OBSERVE: begin
          active = (tgt_count > TARGETS) ? TARGETS : tgt_count;
          n_observed++;
          for (t = 0; t < active; t++) begin
            // return first, then entry, for the same target
            if (pending[t] && it.inst_pc == ret_pc[t] &&
                it.stack_pointer == ret_sp[t] && !it.in_delay_slot) begin
              pending[t] = 1'b0;
              store_match(t, KIND_RETURN, it);
            end
            if (it.inst_pc == tgt_pc[t]) begin
              store_match(t, KIND_ENTRY, it);
              if (follow[t] && !pending[t] &&
                  (it.return_address & ALIGN_MASK) == '0) begin
                ret_pc[t]  = it.return_address;
                ret_sp[t]  = it.stack_pointer;
                pending[t] = 1'b1;
              end
            end
          end
        end
        OP_SET_FIELD: field = it.field_number;
        OP_DRAIN: begin
          res = '0;
          if (records.size() != 0) begin
            r = records.pop_front();
            res.record_present = 1'b1;
            res.rec_ordinal    = r.ordinal;
            res.rec_field      = r.field;
            res.rec_target     = r.target;
            res.rec_kind       = r.kind;
            res.rec_pc         = r.pc;
            res.rec_next_pc    = r.next_pc;
            res.rec_inst       = r.inst;
            res.rec_delay_slot = r.delay_slot;
            res.rec_load_reg   = r.load_reg;
            res.rec_load_value = r.load_data;
            res.rec_stamp      = r.stamp;
          end
          expected_drains.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_drain(crtc_result_t got);
      crtc_result_t want;
      if (expected_drains.size() == 0) begin
        report("result item with no drain outstanding");
        return;
      end
      want = expected_drains.pop_front();
      compare_field("record_present", 32'(got.record_present), 32'(want.record_present));
      compare_field("rec_ordinal", got.rec_ordinal, want.rec_ordinal);
      compare_field("rec_field", got.rec_field, want.rec_field);
      compare_field("rec_target", 32'(got.rec_target), 32'(want.rec_target));
      compare_field("rec_kind", 32'(got.rec_kind), 32'(want.rec_kind));
      compare_field("rec_pc", got.rec_pc, want.rec_pc);
      compare_field("rec_next_pc", got.rec_next_pc, want.rec_next_pc);
      compare_field("rec_inst", got.rec_inst, want.rec_inst);
      compare_field("rec_delay_slot", 32'(got.rec_delay_slot), 32'(want.rec_delay_slot));
      compare_field("rec_load_reg", 32'(got.rec_load_reg), 32'(want.rec_load_reg));
      compare_field("rec_load_value", got.rec_load_value, want.rec_load_value);
      compare_field("rec_stamp", got.rec_stamp, want.rec_stamp);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  int                   quiet = 0;

  // aligned return addresses and stack values that calls reuse
  logic [31:0] ra_pool [4] = '{32'h0000_1000, 32'h8000_0004, 32'hFFFF_FFFC, 32'h0040_0000};
  logic [31:0] sp_pool [3] = '{32'h801F_FF00, 32'h801F_FE00, 32'h0000_0000};

  capture_board sb;

  crtc_in_if  in_ch ();
  crtc_out_if out_ch ();

  call_return_trace_capture dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic crtc_item_t random_payload();
    crtc_item_t it;
    it.opcode             = OP_OBSERVE;
    it.inst_pc            = $urandom;
    it.following_pc       = $urandom;
    it.inst_word          = $urandom;
    it.in_delay_slot      = 1'($urandom);
    it.pending_load_reg   = 6'($urandom);
    it.pending_load_value = $urandom;
    it.cycle_stamp        = $urandom;
    it.stack_pointer      = $urandom;
    it.return_address     = $urandom;
    it.field_number       = $urandom;
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.note_write(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] count, cap, mask,
                                input logic [31:0] pc0, pc1, pc2, pc3);
    write_reg(REG_TARGET_COUNT, count);
    write_reg(REG_QUEUE_CAPACITY, cap);
    write_reg(REG_FOLLOW_MASK, mask);
    write_reg(REG_TARGET_PC_0, pc0);
    write_reg(REG_TARGET_PC_1, pc1);
    write_reg(REG_TARGET_PC_2, pc2);
    write_reg(REG_TARGET_PC_3, pc3);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input crtc_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_item(it);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every drain to come back, then let an observe finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_drains.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic observe(input logic [31:0] pc, sp, ra, input logic slot);
    crtc_item_t it;
    it = random_payload();
    it.inst_pc        = pc;
    it.stack_pointer  = sp;
    it.return_address = ra;
    it.in_delay_slot  = slot;
    send_item(it);
  endtask

  task automatic command(input logic [1:0] op, input logic [31:0] field);
    crtc_item_t it;
    it = random_payload();
    it.opcode       = op;
    it.field_number = field;
    send_item(it);
  endtask

  task automatic random_item(input int drain_pct, output crtc_item_t it);
    int roll;
    int t;
    it   = random_payload();
    roll = $urandom_range(0, 99);
    t    = $urandom_range(0, TARGETS - 1);
    if (roll < drain_pct) begin
      it.opcode = OP_DRAIN;
    end else if (roll < drain_pct + 8) begin
      it.opcode = OP_SET_FIELD;
    end else if (roll < drain_pct + 10) begin
      it.opcode = OP_UNUSED;
    end else if (roll < drain_pct + 40) begin
      // call into a watched target, mostly with a clean return address
      it.inst_pc       = sb.tgt_pc[t];
      it.stack_pointer = sp_pool[$urandom_range(0, 2)];
      if ($urandom_range(0, 9) != 0)
        it.return_address = ra_pool[$urandom_range(0, 3)];
    end else if (roll < drain_pct + 70) begin
      // return, matching a pending call where there is one
      it.in_delay_slot = ($urandom_range(0, 6) == 0);
      if (sb.pending[t]) begin
        it.inst_pc       = sb.ret_pc[t];
        it.stack_pointer = ($urandom_range(0, 6) == 0) ? sp_pool[$urandom_range(0, 2)]
                                                       : sb.ret_sp[t];
      end else begin
        it.inst_pc       = ra_pool[$urandom_range(0, 3)];
        it.stack_pointer = sp_pool[$urandom_range(0, 2)];
      end
    end
  endtask

  task automatic run_phase(input int n_items, input int drain_pct);
    crtc_item_t it;
    int sent;
    int burst;
    sent  = 0;
    burst = 0;
    while (sent < n_items) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
      random_item(drain_pct, it);
      send_item(it);
      burst--;
      if (it.opcode != OP_UNUSED) sent++;
    end
    settle();
  endtask

  // Receiver: hold ready in one stall mode for a stretch, then pick another
  initial begin
    stall_mode_t mode;
    int left;
    out_ch.ready <= 1'b0;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        STALL_NONE:  out_ch.ready <= 1'b1;
        STALL_HALF:  out_ch.ready <= 1'($urandom);
        STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ((left % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_drain(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_call_return_trace_capture: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    crtc_item_t it;
    sb = new();
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, return corner cases
    apply_settings(4, 64, 4'hF, 32'h0, 32'hFFFF_FFFC, 32'h8000_0000, 32'h8000_0000);
    command(OP_DRAIN, 32'h0);                         // empty store
    command(OP_SET_FIELD, 32'hFFFF_FFFF);
    it = '1;
    it.opcode = OP_OBSERVE;
    send_item(it);
    it = '0;
    send_item(it);                                    // entry at address zero
    observe(32'h0, 32'h0, 32'h0000_1000, 1'b0);       // return and re-entry together
    observe(32'h0, 32'h0, 32'h0000_2000, 1'b0);       // entry while pending
    observe(32'h0000_1000, 32'h0, 32'h0, 1'b1);       // delay slot blocks the return
    observe(32'h0000_1000, 32'h4, 32'h0, 1'b0);       // stack pointer differs
    observe(32'h0000_1000, 32'h0, 32'h0, 1'b0);
    observe(32'hFFFF_FFFC, 32'h8, 32'h0000_1003, 1'b0); // misaligned return address
    observe(32'h8000_0000, 32'h8, 32'h8000_0000, 1'b0); // duplicate targets
    observe(32'h8000_0000, 32'h8, 32'h0000_3000, 1'b0);
    observe(32'h0000_3000, 32'h8, 32'h0, 1'b0);
    command(OP_UNUSED, 32'h0);
    command(OP_SET_FIELD, 32'h0);
    repeat (9) command(OP_DRAIN, 32'h0);
    settle();

    apply_settings(1, 64, 4'h1, 32'h0040_0000, 32'h0040_0100, 32'h8000_0000,
                   32'hBFC0_0000);
    run_phase(120, 25);
    // few drains: fill the store and overflow it
    apply_settings(4, 64, 4'hF, 32'h0040_0000, 32'h0000_1000, 32'h8000_0004,
                   32'hFFFF_FFFC);
    run_phase(150, 8);
    // capacity below the current fill
    apply_settings(4, 1, 4'hF, 32'h0040_0000, 32'h0040_0000, 32'h0000_1000,
                   32'h8000_0004);
    run_phase(130, 30);
    apply_settings(0, 0, 4'h0, $urandom, $urandom, $urandom, $urandom);
    run_phase(60, 20);
    // count and capacity above range, misaligned target addresses
    apply_settings(32'h0000_0107, 127, 4'hA, 32'hFFFF_FFFF, 32'h0000_0002,
                   32'h0040_0000, 32'h0);
    run_phase(150, 22);
    apply_settings(3, 3, 4'h5, 32'h8000_0004, 32'h0000_1000, 32'hFFFF_FFFC,
                   32'h0040_0000);
    run_phase(120, 25);
    apply_settings(2, 64, 4'h3, 32'h0000_1000, 32'h0040_0000, 32'h0,
                   32'h0);
    run_phase(120, 20);

    if (sb.errors == 0)
      $display("tb_call_return_trace_capture: clean");
    else
      $display("tb_call_return_trace_capture: errors");
    $finish;
  end

endmodule
